// ----- hdl/clt_pkg.sv -----
package clt_pkg;

  // Scan mode codes held between items.
  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_WORD    = 4'd1;
  localparam logic [3:0] M_DOLLAR  = 4'd2;
  localparam logic [3:0] M_BANG    = 4'd3;
  localparam logic [3:0] M_EXPR    = 4'd4;
  localparam logic [3:0] M_BRACKET = 4'd5;
  localparam logic [3:0] M_DQUOTE  = 4'd6;
  localparam logic [3:0] M_SQUOTE  = 4'd7;
  localparam logic [3:0] M_PAREN   = 4'd8;
  localparam logic [3:0] M_BTICK   = 4'd9;
  localparam logic [3:0] M_DROP    = 4'd10;

  // Error codes.
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_EXPR   = 2'd1;
  localparam logic [1:0] ERR_STRING = 2'd2;
  localparam logic [1:0] ERR_CHAR   = 2'd3;

  // Characters with a special meaning.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_BTICK  = 8'h60;

  // Flags that go with one result item.
  typedef struct packed {
    logic       is_content;
    logic       starts_token;
    logic       ends_before;
    logic       ends_with;
    logic       line_done;
    logic [1:0] error_code;
  } tok_flags_t;

  // Letters, digits and _ . = $ make up a word.
  function automatic logic word_char(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h7A) ||
           (b >= 8'h41 && b <= 8'h5A) || b == CH_UNDER || b == CH_DOT ||
           b == CH_EQUAL || b == CH_DOLLAR;
  endfunction

  function automatic logic line_end(input logic [7:0] b);
    return b == CH_NUL || b == CH_LF;
  endfunction

endpackage

// ----- hdl/clt_if.sv -----
// Channel that carries command bytes into the block.
interface clt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// Channel that carries marked bytes out of the block.
interface clt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       is_content;
  logic       starts_token;
  logic       ends_before;
  logic       ends_with;
  logic       line_done;
  logic [1:0] error_code;

  modport source (
    output valid, output byte_out, output is_content, output starts_token,
    output ends_before, output ends_with, output line_done, output error_code,
    input ready
  );
  modport sink (
    input valid, input byte_out, input is_content, input starts_token,
    input ends_before, input ends_with, input line_done, input error_code,
    output ready
  );
endinterface

// ----- hdl/clt_scan.sv -----
// Classifies one byte against the current scan mode and gives the flags
// of its result item and the mode for the next byte.
module clt_scan (
  input  logic [3:0]          mode,
  input  logic [7:0]          b,
  output clt_pkg::tok_flags_t flags,
  output logic [3:0]          mode_next
);

  clt_pkg::tok_flags_t idle_f;
  logic [3:0]          idle_mode;
  clt_pkg::tok_flags_t word_f;
  logic [3:0]          word_mode;
  clt_pkg::tok_flags_t group_f;
  logic [3:0]          group_mode;
  logic [7:0]          close_ch;
  logic [1:0]          open_err;
  logic                keep;

  // Between tokens: skip blanks, end the line, open a token, or flag an unexpected character.
  always_comb begin
    idle_f    = '0;
    idle_mode = clt_pkg::M_IDLE;
    priority if (b == clt_pkg::CH_SPACE || b == clt_pkg::CH_TAB) begin
      idle_mode = clt_pkg::M_IDLE;
    end else if (clt_pkg::line_end(b)) begin
      idle_f.line_done = 1'b1;
    end else begin
      idle_f.starts_token = 1'b1;
      idle_f.is_content   = 1'b1;
      priority if (b == clt_pkg::CH_DOLLAR) begin
        idle_mode = clt_pkg::M_DOLLAR;
      end else if (b == clt_pkg::CH_BANG) begin
        idle_mode = clt_pkg::M_BANG;
      end else if (b == clt_pkg::CH_DQUOTE) begin
        idle_mode = clt_pkg::M_DQUOTE;
      end else if (b == clt_pkg::CH_SQUOTE) begin
        idle_mode = clt_pkg::M_SQUOTE;
      end else if (b == clt_pkg::CH_LPAREN) begin
        idle_mode = clt_pkg::M_PAREN;
      end else if (b == clt_pkg::CH_BTICK) begin
        idle_mode         = clt_pkg::M_BTICK;
        idle_f.is_content = 1'b0;
      end else if (clt_pkg::word_char(b)) begin
        idle_mode = clt_pkg::M_WORD;
      end else begin
        idle_f.starts_token = 1'b0;
        idle_f.is_content   = 1'b0;
        idle_f.error_code   = clt_pkg::ERR_CHAR;
        idle_mode           = clt_pkg::M_DROP;
      end
    end
  end

  // Inside a word: go on, or close the word and treat the byte as new.
  always_comb begin
    if (clt_pkg::word_char(b)) begin
      word_f            = '0;
      word_f.is_content = 1'b1;
      word_mode         = clt_pkg::M_WORD;
    end else begin
      word_f             = idle_f;
      word_f.ends_before = 1'b1;
      word_mode          = idle_mode;
    end
  end

  // Closing delimiter and error code of the open group.
  always_comb begin
    close_ch = clt_pkg::CH_RPAREN;
    open_err = clt_pkg::ERR_STRING;
    keep     = 1'b1;
    unique case (mode)
      clt_pkg::M_EXPR: begin
        open_err = clt_pkg::ERR_EXPR;
      end
      clt_pkg::M_BRACKET: begin
        close_ch = clt_pkg::CH_RBRACK;
        open_err = clt_pkg::ERR_EXPR;
      end
      clt_pkg::M_DQUOTE: close_ch = clt_pkg::CH_DQUOTE;
      clt_pkg::M_SQUOTE: close_ch = clt_pkg::CH_SQUOTE;
      clt_pkg::M_BTICK: begin
        close_ch = clt_pkg::CH_BTICK;
        keep     = 1'b0;
      end
      default: close_ch = clt_pkg::CH_RPAREN;
    endcase
  end

  // Inside a group: close it, fail on NUL, or take the byte as content.
  always_comb begin
    group_f    = '0;
    group_mode = mode;
    priority if (b == close_ch) begin
      group_f.is_content = keep;
      group_f.ends_with  = 1'b1;
      group_mode         = clt_pkg::M_IDLE;
    end else if (b == clt_pkg::CH_NUL) begin
      group_f.error_code = open_err;
      group_f.line_done  = 1'b1;
      group_mode         = clt_pkg::M_IDLE;
    end else begin
      group_f.is_content = 1'b1;
    end
  end

  // Select by mode.
  always_comb begin
    flags     = '0;
    mode_next = mode;
    unique case (mode)
      clt_pkg::M_WORD: begin
        flags     = word_f;
        mode_next = word_mode;
      end
      clt_pkg::M_DOLLAR: begin
        if (b == clt_pkg::CH_LPAREN) begin
          flags.is_content = 1'b1;
          mode_next        = clt_pkg::M_EXPR;
        end else begin
          flags     = word_f;
          mode_next = word_mode;
        end
      end
      clt_pkg::M_BANG: begin
        if (b == clt_pkg::CH_LBRACK) begin
          flags.is_content = 1'b1;
          mode_next        = clt_pkg::M_BRACKET;
        end else begin
          flags.error_code = clt_pkg::ERR_CHAR;
          if (clt_pkg::line_end(b)) begin
            flags.line_done = 1'b1;
            mode_next       = clt_pkg::M_IDLE;
          end else begin
            mode_next = clt_pkg::M_DROP;
          end
        end
      end
      clt_pkg::M_EXPR, clt_pkg::M_BRACKET, clt_pkg::M_DQUOTE,
      clt_pkg::M_SQUOTE, clt_pkg::M_PAREN, clt_pkg::M_BTICK: begin
        flags     = group_f;
        mode_next = group_mode;
      end
      clt_pkg::M_DROP: begin
        if (clt_pkg::line_end(b)) begin
          flags.line_done = 1'b1;
          mode_next       = clt_pkg::M_IDLE;
        end
      end
      default: begin
        flags     = idle_f;
        mode_next = idle_mode;
      end
    endcase
  end

endmodule

// ----- hdl/command_line_tokenizer.sv -----
// Command-line tokenizer: takes one byte per item and returns one marked
// item per byte, echoing the byte with token start, content, end, line-end
// and error flags. It accepts a byte in every cycle and delivers one result
// per cycle while the sink is ready; a byte passes through an input register,
// then a result register. The only state carried from byte to byte is a
// 4-bit scan mode updated as a byte moves into the result register. Stalls
// on the output propagate back one register at a time, so no item is lost
// or repeated.
module command_line_tokenizer (
  input logic       clk,
  input logic       rst,
  clt_in_if.sink    cmd,
  clt_out_if.source tok
);

  logic                s1_valid;
  logic [7:0]          s1_byte;
  logic                out_valid;
  logic [7:0]          out_byte;
  clt_pkg::tok_flags_t out_flags;
  logic [3:0]          mode;
  logic [3:0]          mode_next;
  clt_pkg::tok_flags_t scan_flags;
  logic                adv;

  clt_scan u_scan (
    .mode      (mode),
    .b         (s1_byte),
    .flags     (scan_flags),
    .mode_next (mode_next)
  );

  // The input stage moves on when the result register is free or emptying.
  assign adv       = s1_valid && (!out_valid || tok.ready);
  assign cmd.ready = !s1_valid || adv;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      mode      <= clt_pkg::M_IDLE;
    end else begin
      if (cmd.valid && cmd.ready) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv) begin
        out_valid <= 1'b1;
        mode      <= mode_next;
      end else if (tok.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_byte <= cmd.in_byte;
    end
    if (adv) begin
      out_byte  <= s1_byte;
      out_flags <= scan_flags;
    end
  end

  assign tok.valid        = out_valid;
  assign tok.byte_out     = out_byte;
  assign tok.is_content   = out_flags.is_content;
  assign tok.starts_token = out_flags.starts_token;
  assign tok.ends_before  = out_flags.ends_before;
  assign tok.ends_with    = out_flags.ends_with;
  assign tok.line_done    = out_flags.line_done;
  assign tok.error_code   = out_flags.error_code;

  // A byte that carries an error never counts as token content.
  a_err_no_content: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_flags.error_code != clt_pkg::ERR_NONE |-> !out_flags.is_content)
    else $error("error item marked as content");

  // An unexpected character that does not end the line starts dropping.
  a_err_drops: assert property (@(posedge clk) disable iff (rst)
    adv && scan_flags.error_code == clt_pkg::ERR_CHAR && !scan_flags.line_done
    |=> mode == clt_pkg::M_DROP)
    else $error("unexpected character did not enter drop mode");

  // A held input byte stays put until the result register takes it.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv |=> s1_valid && $stable(s1_byte))
    else $error("input stage lost its byte");

  // The end of the line always leaves the scanner between tokens.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    adv && scan_flags.line_done |=> mode == clt_pkg::M_IDLE)
    else $error("line end did not return to idle");

endmodule
